@@ sv/quaternion_product_rotate_macros.svh @@
// assertion macros for the quaternion product and rotation checker
`ifndef QUATERNION_PRODUCT_ROTATE_MACROS_SVH
`define QUATERNION_PRODUCT_ROTATE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define QPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define QPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qpr_pkg.sv @@
// shared types, widths and tables for the quaternion product and rotation block
`timescale 1ns / 1ps
`default_nettype none

package qpr_pkg;

  // component format
  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_COMP   = 4;
  localparam int NUM_TERM   = 4;
  localparam int NUM_VEC    = 3;

  // first product: full-precision terms and four-term sums
  localparam int PROD1_W = 2 * COMP_WIDTH;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int T_W     = SUM1_W - FRAC_BITS;

  // second product: intermediate times conjugate
  localparam int CONJ_W  = COMP_WIDTH + 1;
  localparam int PROD2_W = T_W + CONJ_W;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int FIN_W   = SUM2_W - FRAC_BITS;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [CONJ_W-1:0]     conj_t;
  typedef logic signed [PROD1_W-1:0]    prod1_t;
  typedef logic signed [SUM1_W-1:0]     sum1_t;
  typedef logic signed [T_W-1:0]        tmp_t;
  typedef logic signed [PROD2_W-1:0]    prod2_t;
  typedef logic signed [SUM2_W-1:0]     sum2_t;
  typedef logic signed [FIN_W-1:0]      fin_t;
  typedef logic [1:0]                   idx_t;

  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } op_t;

  // load enables of the two register stages inside one product unit
  typedef struct packed {
    logic mul;
    logic acc;
  } stage_en_t;

  typedef struct packed {
    logic  clip;
    comp_t val;
  } sat_t;

  localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
  localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_WIDTH-1){1'b0}}});

  // half an lsb, added before the rounding shift
  localparam sum1_t HALF1 = sum1_t'(1 << (FRAC_BITS - 1));
  localparam sum2_t HALF2 = sum2_t'(1 << (FRAC_BITS - 1));

  // hamilton product p*q: term k of row r is p[P_IDX[k]] * q[Q_IDX[r][k]]
  localparam idx_t P_IDX [NUM_TERM] = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam idx_t Q_IDX [NUM_COMP][NUM_TERM] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  // terms that are subtracted
  localparam logic T_NEG [NUM_COMP][NUM_TERM] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

  // clip a rounded value to the component range
  function automatic sat_t sat_comp(input fin_t v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = comp_t'(v);
    if (v > fin_t'(COMP_MAX)) begin
      s.clip = 1'b1;
      s.val  = COMP_MAX;
    end else if (v < fin_t'(COMP_MIN)) begin
      s.clip = 1'b1;
      s.val  = COMP_MIN;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/quaternion_product_rotate.sv @@
// Fixed-point quaternion unit: operation 0 returns the Hamilton product a*b, operation 1
// rotates the vector (b_x, b_y, b_z) by a as a*(b,0)*conj(a), with r_w held at zero.
// Components are Q2.14; every sum of products is taken at full precision and rounded half
// up, the rotation's intermediate product is kept unsaturated, and final components clip
// to the 16-bit range with saturated set. The datapath is five register stages: products
// and rounded sums of the first Hamilton product, products and rounded sums of the second,
// then saturation into the output register, which drives res_valid. One item is accepted
// every cycle while src_stall is low. Each stage has its own valid bit, so empty stages close
// up while res_stall holds the output register, and src_stall rises only once all five
// stages are full.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_product_rotate import qpr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  src_valid,
  output logic  src_stall,
  input  logic  operation,
  input  comp_t a_x,
  input  comp_t a_y,
  input  comp_t a_z,
  input  comp_t a_w,
  input  comp_t b_x,
  input  comp_t b_y,
  input  comp_t b_z,
  input  comp_t b_w,
  output logic  res_valid,
  input  logic  res_stall,
  output comp_t r_x,
  output comp_t r_y,
  output comp_t r_z,
  output comp_t r_w,
  output logic  saturated
);

  logic      v_m1, v_t1, v_m2, v_u2;
  logic      adv_m1, adv_t1, adv_m2, adv_u2, adv_out;
  stage_en_t en1, en2;
  comp_t     a_in [NUM_COMP];
  comp_t     b_in [NUM_COMP];
  op_t       op1, op2;
  comp_t     a1 [NUM_COMP];
  tmp_t      t1 [NUM_COMP];
  tmp_t      t2 [NUM_COMP];
  fin_t      u2 [NUM_VEC];
  comp_t     r_q [NUM_COMP];

  assign a_in = '{a_x, a_y, a_z, a_w};
  assign b_in = '{b_x, b_y, b_z, b_w};

  // a stage loads when it is empty or its item moves on
  assign adv_out   = !res_valid || !res_stall;
  assign adv_u2    = !v_u2 || adv_out;
  assign adv_m2    = !v_m2 || adv_u2;
  assign adv_t1    = !v_t1 || adv_m2;
  assign adv_m1    = !v_m1 || adv_t1;
  assign src_stall = !adv_m1;

  assign en1 = '{mul: adv_m1, acc: adv_t1};
  assign en2 = '{mul: adv_m2, acc: adv_u2};

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1      <= 1'b0;
      v_t1      <= 1'b0;
      v_m2      <= 1'b0;
      v_u2      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv_m1) begin
        v_m1 <= src_valid;
      end
      if (adv_t1) begin
        v_t1 <= v_m1;
      end
      if (adv_m2) begin
        v_m2 <= v_t1;
      end
      if (adv_u2) begin
        v_u2 <= v_m2;
      end
      if (adv_out) begin
        res_valid <= v_u2;
      end
    end
  end

  // first product a*b or a*(b,0)
  qpr_hprod1 u_hprod1 (
    .clk    (clk),
    .en     (en1),
    .op_in  (op_t'(operation)),
    .a_in   (a_in),
    .b_in   (b_in),
    .op_out (op1),
    .a_out  (a1),
    .t_out  (t1)
  );

  // second product t*conj(a)
  qpr_hprod2 u_hprod2 (
    .clk    (clk),
    .en     (en2),
    .op_in  (op1),
    .a_in   (a1),
    .t_in   (t1),
    .op_out (op2),
    .t_out  (t2),
    .u_out  (u2)
  );

  // saturation and output register
  qpr_sat u_sat (
    .clk     (clk),
    .en      (adv_out),
    .op_in   (op2),
    .t_in    (t2),
    .u_in    (u2),
    .r_out   (r_q),
    .sat_out (saturated)
  );

  assign r_x = r_q[0];
  assign r_y = r_q[1];
  assign r_z = r_q[2];
  assign r_w = r_q[3];

endmodule

`default_nettype wire

@@ sv/qpr_hprod1.sv @@
// first hamilton product a*q: product stage then rounded sum stage
`timescale 1ns / 1ps
`default_nettype none

module qpr_hprod1 import qpr_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  op_t       op_in,
  input  comp_t     a_in [NUM_COMP],
  input  comp_t     b_in [NUM_COMP],
  output op_t       op_out,
  output comp_t     a_out [NUM_COMP],
  output tmp_t      t_out [NUM_COMP]
);

  comp_t  q [NUM_COMP];
  prod1_t prod_next [NUM_COMP][NUM_TERM];
  prod1_t prod [NUM_COMP][NUM_TERM];
  op_t    op_m;
  comp_t  a_m [NUM_COMP];
  sum1_t  acc [NUM_COMP];
  tmp_t   t_next [NUM_COMP];

  // rotation treats b as a pure vector
  always_comb begin
    for (int i = 0; i < NUM_VEC; i++) begin
      q[i] = b_in[i];
    end
    q[NUM_COMP-1] = (op_in == OP_ROTATE) ? '0 : b_in[NUM_COMP-1];
  end

  // sixteen full-precision products
  always_comb begin
    for (int r = 0; r < NUM_COMP; r++) begin
      for (int k = 0; k < NUM_TERM; k++) begin
        prod_next[r][k] = prod1_t'(a_in[P_IDX[k]]) * prod1_t'(q[Q_IDX[r][k]]);
      end
    end
  end

  // signed four-term sums, round half up
  always_comb begin
    for (int r = 0; r < NUM_COMP; r++) begin
      acc[r] = HALF1;
      for (int k = 0; k < NUM_TERM; k++) begin
        if (T_NEG[r][k]) begin
          acc[r] = acc[r] - sum1_t'(prod[r][k]);
        end else begin
          acc[r] = acc[r] + sum1_t'(prod[r][k]);
        end
      end
      t_next[r] = tmp_t'(acc[r] >>> FRAC_BITS);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en.mul) begin
      op_m <= op_in;
      a_m  <= a_in;
      prod <= prod_next;
    end
    if (en.acc) begin
      op_out <= op_m;
      a_out  <= a_m;
      t_out  <= t_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/qpr_hprod2.sv @@
// second hamilton product t*conj(a) for the vector part: product then rounded sum
`timescale 1ns / 1ps
`default_nettype none

module qpr_hprod2 import qpr_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  op_t       op_in,
  input  comp_t     a_in [NUM_COMP],
  input  tmp_t      t_in [NUM_COMP],
  output op_t       op_out,
  output tmp_t      t_out [NUM_COMP],
  output fin_t      u_out [NUM_VEC]
);

  conj_t  c [NUM_COMP];
  prod2_t prod_next [NUM_VEC][NUM_TERM];
  prod2_t prod [NUM_VEC][NUM_TERM];
  op_t    op_m;
  tmp_t   t_m [NUM_COMP];
  sum2_t  acc [NUM_VEC];
  fin_t   u_next [NUM_VEC];

  // conjugate of a, one bit wider so the most negative value negates cleanly
  always_comb begin
    for (int i = 0; i < NUM_VEC; i++) begin
      c[i] = -conj_t'(a_in[i]);
    end
    c[NUM_COMP-1] = conj_t'(a_in[NUM_COMP-1]);
  end

  // products for the three vector rows
  always_comb begin
    for (int r = 0; r < NUM_VEC; r++) begin
      for (int k = 0; k < NUM_TERM; k++) begin
        prod_next[r][k] = prod2_t'(t_in[P_IDX[k]]) * prod2_t'(c[Q_IDX[r][k]]);
      end
    end
  end

  // signed four-term sums, round half up
  always_comb begin
    for (int r = 0; r < NUM_VEC; r++) begin
      acc[r] = HALF2;
      for (int k = 0; k < NUM_TERM; k++) begin
        if (T_NEG[r][k]) begin
          acc[r] = acc[r] - sum2_t'(prod[r][k]);
        end else begin
          acc[r] = acc[r] + sum2_t'(prod[r][k]);
        end
      end
      u_next[r] = fin_t'(acc[r] >>> FRAC_BITS);
    end
  end

  // stage registers, first product carried along for product mode
  always_ff @(posedge clk) begin
    if (en.mul) begin
      op_m <= op_in;
      t_m  <= t_in;
      prod <= prod_next;
    end
    if (en.acc) begin
      op_out <= op_m;
      t_out  <= t_m;
      u_out  <= u_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/qpr_sat.sv @@
// result selection, saturation and output register
`timescale 1ns / 1ps
`default_nettype none

module qpr_sat import qpr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  op_t   op_in,
  input  tmp_t  t_in [NUM_COMP],
  input  fin_t  u_in [NUM_VEC],
  output comp_t r_out [NUM_COMP],
  output logic  sat_out
);

  sat_t  s [NUM_COMP];
  comp_t r_next [NUM_COMP];
  logic  clip_next;

  // pick product or rotation result and clip each component
  always_comb begin
    for (int i = 0; i < NUM_VEC; i++) begin
      s[i] = sat_comp((op_in == OP_ROTATE) ? u_in[i] : fin_t'(t_in[i]));
    end
    if (op_in == OP_ROTATE) begin
      s[NUM_COMP-1] = '0;
    end else begin
      s[NUM_COMP-1] = sat_comp(fin_t'(t_in[NUM_COMP-1]));
    end
    clip_next = 1'b0;
    for (int i = 0; i < NUM_COMP; i++) begin
      r_next[i] = s[i].val;
      clip_next = clip_next | s[i].clip;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      r_out   <= r_next;
      sat_out <= clip_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/qpr_checker.sv @@
// port-level checks for the quaternion product and rotation block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_product_rotate_macros.svh"

module qpr_checker import qpr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  src_valid,
  input logic  src_stall,
  input logic  operation,
  input logic  res_valid,
  input logic  res_stall,
  input comp_t r_x,
  input comp_t r_y,
  input comp_t r_z,
  input comp_t r_w,
  input logic  saturated
);

  // a held result keeps its payload
  `QPR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(r_w) && $stable(saturated), "stalled result changed")

  // the input side stalls only when the output is backed up
  `QPR_ASSERT_NOW(a_stall_cause, src_stall, res_valid && res_stall, "input stalled with output free")

  // a clipped result shows at least one component at a range limit
  `QPR_ASSERT_NOW(a_sat_limit, res_valid && saturated, r_x == COMP_MAX || r_x == COMP_MIN || r_y == COMP_MAX || r_y == COMP_MIN || r_z == COMP_MAX || r_z == COMP_MIN || r_w == COMP_MAX || r_w == COMP_MIN, "saturated without a clipped component")

  // a rotation accepted while res_stall stays low reaches the output with a zero scalar
  `QPR_ASSERT_NEXT(a_rot_latency, (src_valid && !src_stall && operation) ##1 !res_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall, res_valid && r_w == '0, "rotation result late or scalar not zero")

endmodule

bind quaternion_product_rotate qpr_checker u_qpr_checker (.*);

`default_nettype wire
